// ===== sv/ttlpd_pkg.sv =====
package ttlpd_pkg;

  localparam int COORD_W    = 10;
  localparam int TIME_BITS  = 48;
  localparam int RAW_WIDTH  = 1024;
  localparam int RAW_HEIGHT = 600;
  localparam int DIM_W      = 13;
  localparam int MS_TO_US   = 1000;
  localparam int MS_W       = 16;
  localparam int THR_W      = 26;
  localparam int LIMIT_W    = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int EVENT_W    = 2;

  localparam logic [DIM_W-1:0] X_TOP = DIM_W'(RAW_WIDTH - 1);
  localparam logic [DIM_W-1:0] Y_TOP = DIM_W'(RAW_HEIGHT - 1);

  localparam logic [LIMIT_W-1:0] TAP_LIMIT_RST = LIMIT_W'(16);
  localparam logic [THR_W-1:0]   LONG_THR_RST  = THR_W'(500 * MS_TO_US);

  typedef logic [COORD_W-1:0]   coord_t;
  typedef logic [TIME_BITS-1:0] stamp_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_WAIT = 2'd1,
    MODE_SENT = 2'd2
  } mode_t;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE  = 2'd0,
    EV_PRESS = 2'd1,
    EV_TAP   = 2'd2,
    EV_LONG  = 2'd3
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TAP_MOVE = 3'd0,
    CFG_LONG_TAP = 3'd1,
    CFG_SWAP     = 3'd2,
    CFG_INV_X    = 3'd3,
    CFG_INV_Y    = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic   read_ok;
    logic   touched;
    coord_t raw_x;
    coord_t raw_y;
    stamp_t now_us;
  } sample_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] tap_limit;
    logic [THR_W-1:0]   long_thr;
    logic               swap_axes;
    logic               invert_x;
    logic               invert_y;
  } cfg_t;

  function automatic coord_t mirror(input coord_t v, input logic [DIM_W-1:0] top);
    logic [DIM_W-1:0] ve;
    ve = DIM_W'(v);
    return (ve > top) ? '0 : COORD_W'(top - ve);
  endfunction

  function automatic coord_t absdiff(input coord_t a, input coord_t b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// ===== sv/ttlpd_if.sv =====
interface ttlpd_req_if;
  import ttlpd_pkg::*;
  logic   valid;
  logic   ready;
  logic   read_ok;
  logic   touched;
  coord_t raw_x;
  coord_t raw_y;
  stamp_t now_us;

  modport source (output valid, read_ok, touched, raw_x, raw_y, now_us, input ready);
  modport sink (input valid, read_ok, touched, raw_x, raw_y, now_us, output ready);
endinterface

interface ttlpd_rsp_if;
  import ttlpd_pkg::*;
  logic               valid;
  logic               ready;
  logic [EVENT_W-1:0] event_res;
  coord_t             out_x;
  coord_t             out_y;

  modport source (output valid, event_res, out_x, out_y, input ready);
  modport sink (input valid, event_res, out_x, out_y, output ready);
endinterface

// ===== sv/ttlpd_cfg.sv =====
module ttlpd_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [ttlpd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ttlpd_pkg::CFG_DATA_W-1:0]   cfg_data,
  output ttlpd_pkg::cfg_t                    cfg
);
  import ttlpd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tap_limit <= TAP_LIMIT_RST;
      cfg.long_thr  <= LONG_THR_RST;
      cfg.swap_axes <= 1'b1;
      cfg.invert_x  <= 1'b1;
      cfg.invert_y  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TAP_MOVE: cfg.tap_limit <= cfg_data[LIMIT_W-1:0];
        // store the limit in microseconds
        CFG_LONG_TAP: cfg.long_thr <= THR_W'(cfg_data[MS_W-1:0]) * THR_W'(MS_TO_US);
        CFG_SWAP:     cfg.swap_axes <= cfg_data[0];
        CFG_INV_X:    cfg.invert_x <= cfg_data[0];
        CFG_INV_Y:    cfg.invert_y <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/ttlpd_core.sv =====
module ttlpd_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_valid,
  input  ttlpd_pkg::sample_t s,
  output logic               s_take,
  input  ttlpd_pkg::cfg_t    cfg,
  ttlpd_rsp_if.source        rsp
);
  import ttlpd_pkg::*;

  mode_t  mode, mode_next;
  stamp_t start, start_next;
  coord_t press_x, press_x_next, press_y, press_y_next;
  coord_t last_x, last_x_next, last_y, last_y_next;
  logic   moved, moved_next;

  logic   o_valid;
  event_t o_ev, ev_next;
  coord_t o_x, o_y, ox_next, oy_next;

  coord_t mx, my, lx, ly;
  stamp_t elapsed;
  logic   long_hit, drift;

  assign s_take = s_valid && (!o_valid || rsp.ready);

  always_comb begin
    mx       = cfg.invert_x ? mirror(s.raw_x, X_TOP) : s.raw_x;
    my       = cfg.invert_y ? mirror(s.raw_y, Y_TOP) : s.raw_y;
    lx       = cfg.swap_axes ? my : mx;
    ly       = cfg.swap_axes ? mx : my;
    elapsed  = s.now_us - start;
    long_hit = elapsed >= TIME_BITS'(cfg.long_thr);
    drift    = (absdiff(lx, press_x) > cfg.tap_limit) ||
               (absdiff(ly, press_y) > cfg.tap_limit);

    mode_next    = mode;
    start_next   = start;
    press_x_next = press_x;
    press_y_next = press_y;
    last_x_next  = last_x;
    last_y_next  = last_y;
    moved_next   = moved;
    ev_next      = EV_NONE;
    ox_next      = '0;
    oy_next      = '0;

    if (s.read_ok) begin
      case (mode)
        MODE_WAIT: begin
          if (!s.touched) begin
            mode_next = MODE_IDLE;
            if (!moved) begin
              ev_next = EV_TAP;
              ox_next = last_x;
              oy_next = last_y;
            end
          end else begin
            last_x_next = lx;
            last_y_next = ly;
            if (drift) moved_next = 1'b1;
            if (long_hit) begin
              mode_next = MODE_SENT;
              ev_next   = EV_LONG;
            end
          end
        end
        MODE_SENT: begin
          if (!s.touched) mode_next = MODE_IDLE;
        end
        default: begin
          if (s.touched) begin
            press_x_next = lx;
            press_y_next = ly;
            last_x_next  = lx;
            last_y_next  = ly;
            moved_next   = 1'b0;
            mode_next    = MODE_WAIT;
            start_next   = s.now_us;
            ev_next      = EV_PRESS;
            ox_next      = lx;
            oy_next      = ly;
          end else begin
            mode_next = MODE_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_IDLE;
      start   <= '0;
      press_x <= '0;
      press_y <= '0;
      last_x  <= '0;
      last_y  <= '0;
      moved   <= 1'b0;
    end else if (s_take) begin
      mode    <= mode_next;
      start   <= start_next;
      press_x <= press_x_next;
      press_y <= press_y_next;
      last_x  <= last_x_next;
      last_y  <= last_y_next;
      moved   <= moved_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s_take) begin
      o_valid <= 1'b1;
    end else if (rsp.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_take) begin
      o_ev <= ev_next;
      o_x  <= ox_next;
      o_y  <= oy_next;
    end
  end

  assign rsp.valid     = o_valid;
  assign rsp.event_res = o_ev;
  assign rsp.out_x     = o_x;
  assign rsp.out_y     = o_y;

  a_press_arms: assert property (@(posedge clk) disable iff (rst)
    s_take && s.read_ok && s.touched && mode == MODE_IDLE
    |=> mode == MODE_WAIT && o_valid && o_ev == EV_PRESS)
    else $error("touch-down from idle did not arm the press");

  a_fail_holds: assert property (@(posedge clk) disable iff (rst)
    s_take && !s.read_ok |=> o_ev == EV_NONE && $stable(mode) && $stable(start))
    else $error("failed read changed state or gave an event");

  a_zero_coords: assert property (@(posedge clk) disable iff (rst)
    o_valid && (o_ev == EV_NONE || o_ev == EV_LONG) |-> o_x == '0 && o_y == '0)
    else $error("coordinates not zero for none or long tap");

  a_hold_state: assert property (@(posedge clk) disable iff (rst)
    !s_take |=> $stable(mode) && $stable(moved))
    else $error("gesture state moved without a word");

endmodule

// ===== sv/touch_tap_long_press_detector_unit.sv =====
// Channel  Dir  Handshake      Payload
// req      in   valid/ready    read_ok, touched, raw_x, raw_y, now_us
// rsp      out  valid/ready    event_res, out_x, out_y
// cfg      in   cfg_we         cfg_index, cfg_data
//
// One word per cycle sustained while rsp is not stalled; each word passes an
// input register and then a result register.
// The gesture update (48-bit elapsed-time subtract and compare) sits between
// the input register and the result register.
// rst (synchronous) returns the gesture state to idle and loads register defaults.
// A stalled rsp holds its word; req.ready drops only when both registers are full.
module touch_tap_long_press_detector_unit (
  input  logic                             clk,
  input  logic                             rst,
  ttlpd_req_if.sink                        req,
  ttlpd_rsp_if.source                      rsp,
  input  logic                             cfg_we,
  input  logic [ttlpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ttlpd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ttlpd_pkg::*;

  cfg_t    cfg;
  logic    s_valid;
  sample_t s;
  logic    s_take;

  assign req.ready = !s_valid || s_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      s_valid <= 1'b1;
    end else if (s_take) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s.read_ok <= req.read_ok;
      s.touched <= req.touched;
      s.raw_x   <= req.raw_x;
      s.raw_y   <= req.raw_y;
      s.now_us  <= req.now_us;
    end
  end

  ttlpd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ttlpd_core u_core (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_valid),
    .s       (s),
    .s_take  (s_take),
    .cfg     (cfg),
    .rsp     (rsp)
  );

endmodule
